[rtl/tag_allowlist_flap_controller_macros.svh]
// ---------------------------------------------------------------------------
// Tag allowlist flap controller: assertion macros
// Concurrent assertion wrappers clocked on i_clk. The checks drop out
// entirely when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TAG_ALLOWLIST_FLAP_CONTROLLER_MACROS_SVH
`define TAG_ALLOWLIST_FLAP_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
// Assertion that is switched off while reset is held.
`define TAFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Assertion that is checked in every cycle, reset included.
`define TAFC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define TAFC_ASSERT(lbl, prop, msg)
`define TAFC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/tafc_pkg.sv]
// ---------------------------------------------------------------------------
// Tag allowlist flap controller package
// Shared defaults, field widths and codes for the controller.
// ---------------------------------------------------------------------------
package tafc_pkg;

    // Default sizes of the allowlist.
    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int TAG_BYTES_DEF     = 8;

    // Field widths.
    localparam int MODE_W   = 2;
    localparam int TAG_ID_W = 64;
    localparam int BATT_W   = 7;
    localparam int SECS_W   = 8;
    localparam int RCOUNT_W = 4;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 16;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_CLOSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BATT   = 2'd1;

    // Register reset values.
    localparam logic [SECS_W-1:0] AUTO_CLOSE_RST = 8'd20;
    localparam logic [BATT_W-1:0] LOW_BATT_RST   = 7'd10;

    // Event kinds.
    localparam logic [MODE_W-1:0] MODE_TAG   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_NONE       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REGISTERED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

endpackage

[rtl/tafc_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
module tafc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/tag_allowlist_flap_controller.sv]
// ---------------------------------------------------------------------------
// Tag allowlist flap controller
// Matches RFID tag reads against a stored allowlist and drives a flap,
// with an automatic close timer and a low battery indicator.
// ---------------------------------------------------------------------------
// Usage:
// Events arrive on the s_axis channel: tuser carries the event kind (tag
// read, one-second tick, enter add mode, reset flap), tdata carries the tag
// identifier in bits 63:0 and the battery sample in bits 70:64. Each event
// gives exactly one result transfer on m_axis, showing the state after the
// event together with a status code.
// A tag read outside add mode walks the allowlist through one RAM read port,
// one entry a cycle, and stops at the first match. Every other event goes
// straight to the output state. The input is ready only while no event is
// in progress.
// The two configuration registers are written through i_cfg_we, i_cfg_idx
// and i_cfg_data; writes to unused indexes are ignored.
// Reset empties the allowlist, closes the flap, clears add mode and the
// battery flag, and restores the register defaults. No clearing pass runs.
// If the receiver stalls, the result is held on m_axis and the next event
// can be taken; its own result then waits for the held one to go.
// ---------------------------------------------------------------------------
`include "tag_allowlist_flap_controller_macros.svh"

module tag_allowlist_flap_controller
    import tafc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int TAG_BYTES     = TAG_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Event input.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // tag_id[63:0], battery_level[70:64], zeros
    input  logic [MODE_W-1:0]     s_axis_tuser,   // mode[1:0]
    // Result output.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata    // flap_open[0], low_battery[1],
                                                  // add_mode_active[2],
                                                  // registered_count[6:3], status[9:7], zeros
);

    localparam int TAG_W = 8 * TAG_BYTES;
    localparam int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    // Input fields.
    logic [TAG_W-1:0]  in_tag;
    logic [BATT_W-1:0] in_batt;
    logic              in_xfer;

    assign in_tag  = s_axis_tdata[TAG_W-1:0];
    assign in_batt = s_axis_tdata[TAG_ID_W +: BATT_W];
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // Registers.
    logic [1:0]          r_state,    n_state;
    logic [SECS_W-1:0]   r_auto_close;
    logic [BATT_W-1:0]   r_low_thr;
    logic [CNT_W-1:0]    r_count,    n_count;
    logic                r_open,     n_open;
    logic [SECS_W-1:0]   r_secs,     n_secs;
    logic                r_add,      n_add;
    logic                r_batt_low, n_batt_low;
    logic [STATUS_W-1:0] r_status,   n_status;
    logic [TAG_W-1:0]    r_tag,      n_tag;
    logic [CNT_W-1:0]    r_scan,     n_scan;
    logic                r_pend,     n_pend;
    logic                r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;

    // Table memory signals.
    logic             ram_we;
    logic [AW-1:0]    ram_raddr;
    logic [TAG_W-1:0] ram_rdata;
    logic             scan_issue;
    logic             scan_hit;
    logic [SECS_W-1:0] secs_inc;
    logic             out_free;

    tafc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (in_tag),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Append a tag on a tag read in add mode while there is room.
    assign ram_we = in_xfer && (s_axis_tuser == MODE_TAG) && r_add && (r_count < CNT_FULL);

    // Scan walks the stored entries; the comparison runs in the cycle after the read.
    assign scan_issue = r_scan < r_count;
    assign ram_raddr  = r_scan[AW-1:0];
    assign scan_hit   = r_pend && (ram_rdata == r_tag);

    assign secs_inc = (r_secs != {SECS_W{1'b1}}) ? r_secs + SECS_W'(1) : r_secs;
    assign out_free = !r_m_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);

    // Sequencer and state update.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_open     = r_open;
        n_secs     = r_secs;
        n_add      = r_add;
        n_batt_low = r_batt_low;
        n_status   = r_status;
        n_tag      = r_tag;
        n_scan     = r_scan;
        n_pend     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_status = ST_NONE;
                    n_state  = S_OUT;
                    case (s_axis_tuser)
                        MODE_TAG: begin
                            if (r_add) begin
                                n_add = 1'b0;
                                if (r_count < CNT_FULL) begin
                                    n_count  = r_count + CNT_W'(1);
                                    n_status = ST_REGISTERED;
                                end else begin
                                    n_status = ST_FULL;
                                end
                            end else begin
                                n_tag   = in_tag;
                                n_scan  = '0;
                                n_state = S_SCAN;
                            end
                        end
                        MODE_TICK: begin
                            if (r_open) begin
                                if (secs_inc >= r_auto_close) begin
                                    n_open = 1'b0;
                                    n_secs = '0;
                                end else begin
                                    n_secs = secs_inc;
                                end
                            end
                            n_batt_low = in_batt < r_low_thr;
                        end
                        MODE_ADD: begin
                            n_add = 1'b1;
                        end
                        default: begin
                            n_open = 1'b0;
                            n_secs = '0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_open   = 1'b1;
                    n_secs   = '0;
                    n_status = ST_ACCEPTED;
                    n_state  = S_OUT;
                end else if (!scan_issue) begin
                    n_open   = 1'b0;
                    n_secs   = '0;
                    n_status = ST_REJECTED;
                    n_state  = S_OUT;
                end else begin
                    n_pend = 1'b1;
                    n_scan = r_scan + CNT_W'(1);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_open     <= 1'b0;
            r_secs     <= '0;
            r_add      <= 1'b0;
            r_batt_low <= 1'b0;
            r_pend     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_open     <= n_open;
            r_secs     <= n_secs;
            r_add      <= n_add;
            r_batt_low <= n_batt_low;
            r_pend     <= n_pend;
        end
    end

    // Working registers of the current event.
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_tag    <= n_tag;
        r_scan   <= n_scan;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_close <= AUTO_CLOSE_RST;
            r_low_thr    <= LOW_BATT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_AUTO_CLOSE: r_auto_close <= i_cfg_data;
                REG_LOW_BATT:   r_low_thr    <= i_cfg_data[BATT_W-1:0];
                default: ;
            endcase
        end
    end

    // Output register: loaded when the result is ready and the previous one has gone.
    logic [CNT_W+RCOUNT_W-1:0] count_ext;
    logic                      out_load;

    assign count_ext = {{RCOUNT_W{1'b0}}, r_count};
    assign out_load  = (r_state == S_OUT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {6'd0, r_status, count_ext[RCOUNT_W-1:0], r_add, r_batt_low, r_open};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Assertions.
    `TAFC_ASSERT(a_count_bound, r_count <= CNT_FULL, "allowlist count beyond table size")
    `TAFC_ASSERT(a_timer_closed, !r_open |-> (r_secs == '0), "timer running with flap closed")
    `TAFC_ASSERT(a_append_count, ram_we |=> (r_count == $past(r_count) + CNT_W'(1)),
        "append did not advance the count")
    `TAFC_ASSERT(a_short_event, (in_xfer && s_axis_tuser != MODE_TAG) |=> (r_state == S_OUT),
        "non-scan event did not go to output")
    `TAFC_ASSERT(a_scan_only_idle_add, (r_state == S_SCAN) |-> !r_add, "scan started in add mode")

endmodule
